>>> hdl/cjr_pkg.sv
// ---------------------------------------------------------------------------
// cjr_pkg
// Shared types and codes for the conveyor jam-recovery controller.
// ---------------------------------------------------------------------------
`default_nettype none

package cjr_pkg;

  localparam int unsigned MV_W    = 15;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CUR_W   = 16;
  localparam int unsigned SPD_W   = 13;
  localparam int unsigned RPM_W   = 12;
  localparam int unsigned RETRY_W = 4;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 16;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_MODE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_FWD   = 2'd1,
    MODE_REV   = 2'd2,
    MODE_INDEX = 2'd3
  } mode_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FORWARD_MV  = 3'd0,
    CFG_REVERSE_MV  = 3'd1,
    CFG_INDEX_MV    = 3'd2,
    CFG_UNJAM_MV    = 3'd3,
    CFG_STALL_CUR   = 3'd4,
    CFG_STALL_SPD   = 3'd5,
    CFG_STALL_DWELL = 3'd6,
    CFG_RETRY_LIMIT = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [MV_W-1:0] forward_mv;
    logic signed [MV_W-1:0] reverse_mv;
    logic signed [MV_W-1:0] index_mv;
    logic signed [MV_W-1:0] unjam_mv;
    logic [CUR_W-1:0]       stall_current_ma;
    logic [RPM_W-1:0]       stall_speed_rpm;
    logic [CUR_W-1:0]       stall_dwell_ms;
    logic [RETRY_W-1:0]     retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [1:0]              new_mode;
    logic [TIME_W-1:0]       now_ms;
    logic                    sensor_seen;
    logic [CUR_W-1:0]        motor_current_ma;
    logic signed [SPD_W-1:0] motor_speed_rpm;
  } item_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic signed [MV_W-1:0] drive_level;
    logic                   present_flag;
    logic                   index_latch;
    logic                   stall_timing;
    logic [TIME_W-1:0]      stall_start;
    logic                   clean_timing;
    logic [TIME_W-1:0]      clean_start;
    logic                   burst_active;
    logic [TIME_W-1:0]      burst_start;
    logic [RETRY_W-1:0]     retry_count;
    logic                   jam_flag;
  } state_t;

endpackage

`default_nettype wire

>>> hdl/conveyor_jam_recovery_controller_core.sv
// ---------------------------------------------------------------------------
// conveyor_jam_recovery_controller_core
// Conveyor motor controller with timed reverse unjam and jam latching.
// ---------------------------------------------------------------------------
//
//  channel | dir | ports                 | content
//  --------+-----+-----------------------+-------------------------------------
//  in      | in  | in_tvalid/tready      | tick, mode change or jam clear item
//  out     | out | out_tvalid/tready     | one status item per input item
//  cfg     | in  | cfg_we/addr/wdata     | eight settings, write only
//
//  Throughput is one item per clock while the result is not held. An
//  accepted item waits in the input register; the next-state logic then
//  updates the controller state and loads the result register in the same
//  edge, once the result slot is free. The state loop (state -> next state
//  -> state) is the only feedback path, which sets the one-item rate.
//  A held result does not block intake: the input register takes one more
//  item while the result waits. Reset (rst_n low, synchronous) restores
//  all settings to defaults and clears state and both valid flags.
// ---------------------------------------------------------------------------
`default_nettype none

module conveyor_jam_recovery_controller_core
  import cjr_pkg::*;
#(
  parameter int MAX_MV     = 12000,  // drive clamp, mV
  parameter int BURST_MS   = 200,    // unjam burst length
  parameter int CLEAN_MS   = 500,    // clean run that restores retries
  parameter bit HAS_SENSOR = 1'b1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // [1:0] new_mode, [33:2] now_ms, [34] sensor_seen,
  // [50:35] motor_current_ma, [63:51] motor_speed_rpm
  input  wire logic [63:0]       in_tdata,
  // [1:0] kind
  input  wire logic [1:0]        in_tuser,

  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [14:0] drive_mv, [15] jam_latched, [16] object_present, [17] index_done,
  // [18] unjam_active, [22:19] retries_used, [24:23] mode_now, [31:25] zero
  output logic [31:0]            out_tdata,

  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t   cfg;
  item_t  item_r;
  logic   item_vld_r;
  logic   out_vld_r;
  logic [31:0] out_data_r;
  state_t st_nxt;
  logic   step;

  cjr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // item moves into state/result when the result slot is free or drains now
  assign step      = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.kind             <= in_tuser;
      item_r.new_mode         <= in_tdata[1:0];
      item_r.now_ms           <= in_tdata[33:2];
      item_r.sensor_seen      <= in_tdata[34];
      item_r.motor_current_ma <= in_tdata[50:35];
      item_r.motor_speed_rpm  <= $signed(in_tdata[63:51]);
    end
  end

  cjr_ctrl #(
    .MAX_MV     (MAX_MV),
    .BURST_MS   (BURST_MS),
    .CLEAN_MS   (CLEAN_MS),
    .HAS_SENSOR (HAS_SENSOR)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .cfg    (cfg),
    .st_nxt (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {7'd0, st_nxt.mode, st_nxt.retry_count, st_nxt.burst_active,
                     st_nxt.index_latch, st_nxt.present_flag, st_nxt.jam_flag,
                     st_nxt.drive_level};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> hdl/cjr_cfg_regs.sv
// ---------------------------------------------------------------------------
// cjr_cfg_regs
// Write-only configuration register file.
// ---------------------------------------------------------------------------
`default_nettype none

module cjr_cfg_regs
  import cjr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.forward_mv       <= 15'sd12000;
      cfg_r.reverse_mv       <= -15'sd12000;
      cfg_r.index_mv         <= 15'sd6000;
      cfg_r.unjam_mv         <= -15'sd6000;
      cfg_r.stall_current_ma <= 16'd2000;
      cfg_r.stall_speed_rpm  <= 12'd5;
      cfg_r.stall_dwell_ms   <= 16'd250;
      cfg_r.retry_limit      <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_addr))
        CFG_FORWARD_MV:  cfg_r.forward_mv       <= $signed(cfg_wdata[MV_W-1:0]);
        CFG_REVERSE_MV:  cfg_r.reverse_mv       <= $signed(cfg_wdata[MV_W-1:0]);
        CFG_INDEX_MV:    cfg_r.index_mv         <= $signed(cfg_wdata[MV_W-1:0]);
        CFG_UNJAM_MV:    cfg_r.unjam_mv         <= $signed(cfg_wdata[MV_W-1:0]);
        CFG_STALL_CUR:   cfg_r.stall_current_ma <= cfg_wdata[CUR_W-1:0];
        CFG_STALL_SPD:   cfg_r.stall_speed_rpm  <= cfg_wdata[RPM_W-1:0];
        CFG_STALL_DWELL: cfg_r.stall_dwell_ms   <= cfg_wdata[CUR_W-1:0];
        CFG_RETRY_LIMIT: cfg_r.retry_limit      <= cfg_wdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hdl/cjr_ctrl.sv
// ---------------------------------------------------------------------------
// cjr_ctrl
// Controller state and its single-pass next-state logic for one item.
// ---------------------------------------------------------------------------
`default_nettype none

module cjr_ctrl
  import cjr_pkg::*;
#(
  parameter int MAX_MV     = 12000,
  parameter int BURST_MS   = 200,
  parameter int CLEAN_MS   = 500,
  parameter bit HAS_SENSOR = 1'b1
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,      // apply item this cycle
  input  item_t     item,
  input  cfg_t      cfg,
  output state_t    st_nxt     // state after item
);

  localparam logic signed [MV_W-1:0]   MaxPos   = MV_W'(MAX_MV);
  localparam logic signed [MV_W-1:0]   MaxNeg   = -MV_W'(MAX_MV);
  localparam logic [TIME_W-1:0]        UnjamLen = TIME_W'(BURST_MS);
  localparam logic [TIME_W-1:0]        CleanLen = TIME_W'(CLEAN_MS);

  function automatic logic signed [MV_W-1:0] clamp_mv(input logic signed [MV_W-1:0] v);
    if (v > MaxPos)      clamp_mv = MaxPos;
    else if (v < MaxNeg) clamp_mv = MaxNeg;
    else                 clamp_mv = v;
  endfunction

  state_t st_r;
  state_t nx;

  logic                   done;
  logic signed [MV_W-1:0] v;
  logic [SPD_W-1:0]       mag;
  logic                   stalling;
  logic                   present;
  logic [TIME_W-1:0]      now;

  always_comb begin
    nx       = st_r;
    done     = 1'b0;
    v        = '0;
    now      = item.now_ms;
    present  = HAS_SENSOR ? item.sensor_seen : 1'b0;
    // magnitude as unsigned; the most negative code maps to 4096
    mag      = item.motor_speed_rpm[SPD_W-1] ? SPD_W'(-item.motor_speed_rpm)
                                             : SPD_W'(item.motor_speed_rpm);
    stalling = (item.motor_current_ma > cfg.stall_current_ma) &&
               (mag < {1'b0, cfg.stall_speed_rpm});

    case (kind_e'(item.kind))
      KIND_TICK: begin
        nx.present_flag = present;
        if (st_r.mode == MODE_INDEX && present) nx.index_latch = 1'b1;

        if (st_r.burst_active) begin
          if ((now - st_r.burst_start) < UnjamLen) begin
            nx.drive_level = clamp_mv(cfg.unjam_mv);
            done = 1'b1;
          end else begin
            nx.burst_active = 1'b0;
            nx.stall_timing = 1'b0;
          end
        end
        if (!done && st_r.jam_flag) begin
          nx.drive_level = '0;
          done = 1'b1;
        end
        if (!done) begin
          case (mode_e'(st_r.mode))
            MODE_FWD:   v = clamp_mv(cfg.forward_mv);
            MODE_REV:   v = clamp_mv(cfg.reverse_mv);
            MODE_INDEX: v = (!HAS_SENSOR || present) ? '0 : clamp_mv(cfg.index_mv);
            default:    v = '0;
          endcase
          nx.drive_level = v;
          if (v != '0) begin
            if (!stalling) begin
              nx.stall_timing = 1'b0;
              if (st_r.retry_count != '0) begin
                if (!st_r.clean_timing) begin
                  nx.clean_timing = 1'b1;
                  nx.clean_start  = now;
                end else if ((now - st_r.clean_start) >= CleanLen) begin
                  nx.clean_timing = 1'b0;
                  nx.retry_count  = '0;
                end
              end
            end else if (!st_r.stall_timing) begin
              nx.clean_timing = 1'b0;
              nx.stall_timing = 1'b1;
              nx.stall_start  = now;
            end else if ((now - st_r.stall_start) >=
                         {{(TIME_W-CUR_W){1'b0}}, cfg.stall_dwell_ms}) begin
              nx.stall_timing = 1'b0;
              if (st_r.retry_count >= cfg.retry_limit) begin
                nx.jam_flag    = 1'b1;
                nx.drive_level = '0;
              end else begin
                nx.retry_count  = st_r.retry_count + 1'b1;
                nx.burst_active = 1'b1;
                nx.burst_start  = now;
                nx.drive_level  = clamp_mv(cfg.unjam_mv);
              end
            end
          end else begin
            nx.stall_timing = 1'b0;
            nx.clean_timing = 1'b0;
          end
        end
      end
      KIND_MODE, KIND_CLEAR: begin
        if (kind_e'(item.kind) == KIND_MODE) begin
          nx.mode        = item.new_mode;
          nx.index_latch = 1'b0;
        end
        nx.stall_timing = 1'b0;
        nx.stall_start  = '0;
        nx.clean_timing = 1'b0;
        nx.clean_start  = '0;
        nx.burst_active = 1'b0;
        nx.burst_start  = '0;
        nx.retry_count  = '0;
        nx.jam_flag     = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step) begin
      st_r <= nx;
    end
  end

  assign st_nxt = nx;

endmodule

`default_nettype wire

>>> hdl/cjr_checker.sv
// ---------------------------------------------------------------------------
// cjr_checker
// Port-level checks for the conveyor jam-recovery controller.
// ---------------------------------------------------------------------------
`default_nettype none

module cjr_checker
  import cjr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a latched jam always commands zero drive
  a_jam_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15] |-> out_tdata[14:0] == 15'd0)
    else $error("nonzero drive with jam latched");

  // burst and jam never together
  a_burst_jam: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[15] && out_tdata[18]))
    else $error("unjam burst while jammed");

  // stopped mode never reports an unjam burst
  a_stop_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[24:23] == MODE_STOP |-> !out_tdata[18])
    else $error("unjam burst in stopped mode");

  // reset empties the pipeline and opens intake
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

endmodule

bind conveyor_jam_recovery_controller_core cjr_checker u_cjr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> tb/conveyor_jam_recovery_controller_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conveyor_jam_recovery_controller_core_tb
// Self-checking bench for the conveyor jam-recovery controller. A short
// directed list walks each mode, index stop, stall and unjam burst, clean
// run, clear and ignored items. Phases of random runs with random gaps on
// both channels follow, each with its own drive and stall settings. Every
// status is checked against a cycle-free copy here or a typed-in status.
// ---------------------------------------------------------------------------

module conveyor_jam_recovery_controller_core_tb;
  import cjr_pkg::*;

  localparam int MAX_MV      = 12000;
  localparam int BURST_MS    = 200;
  localparam int CLEAN_MS    = 500;
  localparam bit HAS_SENSOR  = 1'b1;
  localparam int HOLD_CYCLES = 60;    // long output stall, fills the pipe
  localparam int QUIET_LIMIT = 1000;  // cycles with no traffic before giving up
  localparam int TAIL_CYCLES = 4;     // settling margin after the status queue empties
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 80;

  // status word as it sits on out_tdata, low field last
  typedef struct packed {
    logic [6:0]             pad;
    mode_e                  mode_now;
    logic [RETRY_W-1:0]     retries_used;
    logic                   unjam_active;
    logic                   index_done;
    logic                   object_present;
    logic                   jam_latched;
    logic signed [MV_W-1:0] drive_mv;
  } status_t;

  typedef struct packed {
    item_t   it;
    logic    typed;   // expected status written in by hand
    status_t want;
  } row_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata   = '0;
  logic [1:0]        in_tuser   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;
  logic              cfg_we     = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [CFG_DW-1:0] cfg_wdata  = '0;

  // hand-written expectation travels with the item on the bus
  logic    ref_typed = 1'b0;
  status_t ref_want  = '0;

  conveyor_jam_recovery_controller_core #(
    .MAX_MV    (MAX_MV),
    .BURST_MS  (BURST_MS),
    .CLEAN_MS  (CLEAN_MS),
    .HAS_SENSOR(HAS_SENSOR)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Controller copy: settings, state, and one step per accepted item
  // -------------------------------------------------------------------------
  logic signed [MV_W-1:0] fwd_mv    = 12000;
  logic signed [MV_W-1:0] rev_mv    = -12000;
  logic signed [MV_W-1:0] idx_mv    = 6000;
  logic signed [MV_W-1:0] unj_mv    = -6000;
  logic [CUR_W-1:0]       stall_ma  = 2000;
  logic [RPM_W-1:0]       stall_rpm = 5;
  logic [CUR_W-1:0]       dwell_ms  = 250;
  logic [RETRY_W-1:0]     max_tries = 3;

  mode_e                  cur_mode   = MODE_STOP;
  logic signed [MV_W-1:0] drive_now  = '0;
  logic                   sensor_now = 1'b0;
  logic                   index_hit  = 1'b0;
  logic                   stall_on   = 1'b0;
  logic [TIME_W-1:0]      stall_t0   = '0;
  logic                   clean_on   = 1'b0;
  logic [TIME_W-1:0]      clean_t0   = '0;
  logic                   unjam_on   = 1'b0;
  logic [TIME_W-1:0]      unjam_t0   = '0;
  logic [RETRY_W-1:0]     tries      = '0;
  logic                   jammed     = 1'b0;

  status_t status_q[$];   // statuses still owed by the block
  int      err_cnt = 0;

  function automatic void load_setting(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    case (cfg_idx_e'(idx))
      CFG_FORWARD_MV:  fwd_mv    = val[MV_W-1:0];
      CFG_REVERSE_MV:  rev_mv    = val[MV_W-1:0];
      CFG_INDEX_MV:    idx_mv    = val[MV_W-1:0];
      CFG_UNJAM_MV:    unj_mv    = val[MV_W-1:0];
      CFG_STALL_CUR:   stall_ma  = val[CUR_W-1:0];
      CFG_STALL_SPD:   stall_rpm = val[RPM_W-1:0];
      CFG_STALL_DWELL: dwell_ms  = val[CUR_W-1:0];
      CFG_RETRY_LIMIT: max_tries = val[RETRY_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [MV_W-1:0] clamp_mv(logic signed [MV_W-1:0] v);
    if (v > MAX_MV) return MV_W'(MAX_MV);
    if (v < -MAX_MV) return -MV_W'(MAX_MV);
    return v;
  endfunction

  // timers, burst, retry budget and jam all go back to idle
  function automatic void clear_recovery();
    stall_on = 1'b0;
    stall_t0 = '0;
    clean_on = 1'b0;
    clean_t0 = '0;
    unjam_on = 1'b0;
    unjam_t0 = '0;
    tries    = '0;
    jammed   = 1'b0;
  endfunction

  function automatic logic signed [MV_W-1:0] mode_drive();
    case (cur_mode)
      MODE_FWD:   return clamp_mv(fwd_mv);
      MODE_REV:   return clamp_mv(rev_mv);
      MODE_INDEX: begin
        if (!HAS_SENSOR || sensor_now) return '0;
        return clamp_mv(idx_mv);
      end
      default:    return '0;
    endcase
  endfunction

  function automatic void take_tick(item_t it);
    int                     spd;
    int                     mag;
    logic [TIME_W-1:0]      dt;
    logic signed [MV_W-1:0] v;
    logic                   stalling;
    spd = it.motor_speed_rpm;
    mag = (spd < 0) ? -spd : spd;   // -4096 gives 4096
    sensor_now = HAS_SENSOR ? it.sensor_seen : 1'b0;
    if (cur_mode == MODE_INDEX && sensor_now) index_hit = 1'b1;

    if (unjam_on) begin
      dt = it.now_ms - unjam_t0;
      if (dt < BURST_MS) begin
        drive_now = clamp_mv(unj_mv);
        return;
      end
      unjam_on = 1'b0;
      stall_on = 1'b0;
    end
    if (jammed) begin
      drive_now = '0;
      return;
    end

    v = mode_drive();
    if (v != 0) begin
      stalling = (it.motor_current_ma > stall_ma) && (mag < int'(stall_rpm));
      if (!stalling) begin
        stall_on = 1'b0;
        if (tries > 0) begin
          dt = it.now_ms - clean_t0;
          if (!clean_on) begin
            clean_on = 1'b1;
            clean_t0 = it.now_ms;
          end else if (dt >= CLEAN_MS) begin
            clean_on = 1'b0;
            tries    = '0;
          end
        end
      end else if (!stall_on) begin
        clean_on = 1'b0;
        stall_on = 1'b1;
        stall_t0 = it.now_ms;
      end else begin
        dt = it.now_ms - stall_t0;
        if (dt >= dwell_ms) begin
          stall_on = 1'b0;
          if (tries >= max_tries) begin
            jammed    = 1'b1;
            drive_now = '0;
            return;
          end
          tries     = tries + 1'b1;
          unjam_on  = 1'b1;
          unjam_t0  = it.now_ms;
          drive_now = clamp_mv(unj_mv);
          return;
        end
      end
    end else begin
      // no drive for this mode: neither timer runs
      stall_on = 1'b0;
      clean_on = 1'b0;
    end
    drive_now = v;
  endfunction

  function automatic status_t next_status(item_t it);
    status_t s;
    case (kind_e'(it.kind))
      KIND_TICK:  take_tick(it);
      KIND_MODE: begin
        // even a repeat of the current mode restarts recovery
        cur_mode  = mode_e'(it.new_mode);
        index_hit = 1'b0;
        clear_recovery();
      end
      KIND_CLEAR: clear_recovery();
      default: ;  // unknown kind only reports status
    endcase
    s                = '0;
    s.drive_mv       = drive_now;
    s.jam_latched    = jammed;
    s.object_present = sensor_now;
    s.index_done     = index_hit;
    s.unjam_active   = unjam_on;
    s.retries_used   = tries;
    s.mode_now       = cur_mode;
    return s;
  endfunction

  function automatic void check_status(status_t got, status_t want);
    if (got.drive_mv !== want.drive_mv) begin
      $error("drive_mv: expected %0d, got %0d", want.drive_mv, got.drive_mv);
      err_cnt++;
    end
    if (got.jam_latched !== want.jam_latched) begin
      $error("jam_latched: expected %0d, got %0d", want.jam_latched, got.jam_latched);
      err_cnt++;
    end
    if (got.object_present !== want.object_present) begin
      $error("object_present: expected %0d, got %0d", want.object_present, got.object_present);
      err_cnt++;
    end
    if (got.index_done !== want.index_done) begin
      $error("index_done: expected %0d, got %0d", want.index_done, got.index_done);
      err_cnt++;
    end
    if (got.unjam_active !== want.unjam_active) begin
      $error("unjam_active: expected %0d, got %0d", want.unjam_active, got.unjam_active);
      err_cnt++;
    end
    if (got.retries_used !== want.retries_used) begin
      $error("retries_used: expected %0d, got %0d", want.retries_used, got.retries_used);
      err_cnt++;
    end
    if (got.mode_now !== want.mode_now) begin
      $error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
      err_cnt++;
    end
    if (got.pad !== want.pad) begin
      $error("pad: expected %0d, got %0d", want.pad, got.pad);
      err_cnt++;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Scoreboard: settings writes, accepted items and accepted statuses, all
  // sampled at the rising edge
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    item_t   taken;
    status_t calc;
    if (rst_n && cfg_we) load_setting(cfg_addr, cfg_wdata);
    if (rst_n && in_tvalid && in_tready) begin
      taken.kind             = in_tuser;
      taken.new_mode         = in_tdata[1:0];
      taken.now_ms           = in_tdata[33:2];
      taken.sensor_seen      = in_tdata[34];
      taken.motor_current_ma = in_tdata[50:35];
      taken.motor_speed_rpm  = in_tdata[63:51];
      calc = next_status(taken);
      status_q.push_back(ref_typed ? ref_want : calc);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (status_q.size() == 0) begin
        $error("status item with none expected: %h", out_tdata);
        err_cnt++;
      end else begin
        check_status(status_t'(out_tdata), status_q.pop_front());
      end
    end
  end

  // watchdog: ends the run after a long stretch without any traffic
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("conveyor_jam_recovery_controller_core_tb NOT OK");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Status sink: random stalls per item, long hold on request
  // -------------------------------------------------------------------------
  int hold_req = 0;

  initial begin : status_sink
    int holds_done;
    int gap;
    int taken_cnt;
    bit calm;
    holds_done = 0;
    taken_cnt  = 0;
    calm       = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken_cnt % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      taken_cnt++;
      if (hold_req != holds_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  row_t              dir_rows[$];
  int                counted  = 0;   // items that are not ignored
  int                sent_cnt = 0;
  bit                in_calm  = 1'b0;
  logic [TIME_W-1:0] clock_ms = '0;
  int                gen_ma   = 2000;  // stall thresholds as last written
  int                gen_rpm  = 5;

  function automatic item_t random_item();
    item_t it;
    it.kind             = $urandom_range(0, 3);
    it.new_mode         = $urandom_range(0, 3);
    it.now_ms           = $urandom();
    it.sensor_seen      = $urandom_range(0, 1);
    it.motor_current_ma = $urandom_range(0, 65535);
    it.motor_speed_rpm  = $urandom_range(0, 8191);
    return it;
  endfunction

  function automatic item_t make_item(kind_e k, mode_e m, logic [31:0] now, bit seen,
                                      int cur, int spd);
    item_t it;
    it.kind             = k;
    it.new_mode         = m;
    it.now_ms           = now;
    it.sensor_seen      = seen;
    it.motor_current_ma = cur;
    it.motor_speed_rpm  = spd;
    return it;
  endfunction

  function automatic status_t pack_status(int drive, bit jam, bit present, bit idx,
                                          bit unjam, int used, mode_e m);
    status_t s;
    s                = '0;
    s.drive_mv       = drive;
    s.jam_latched    = jam;
    s.object_present = present;
    s.index_done     = idx;
    s.unjam_active   = unjam;
    s.retries_used   = used;
    s.mode_now       = m;
    return s;
  endfunction

  function automatic void add_row(item_t it, bit typed, status_t want);
    row_t r;
    r.it    = it;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  // advances the millisecond clock; a stalled tick has high current, low speed
  function automatic item_t next_tick(bit stalled);
    item_t it;
    int    mag;
    it = random_item();
    it.kind = KIND_TICK;
    clock_ms += ($urandom_range(0, 4) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 60);
    it.now_ms = clock_ms;
    it.sensor_seen = ($urandom_range(0, 3) == 0);
    if (stalled) begin
      it.motor_current_ma = (gen_ma >= 65535) ? 65535 : $urandom_range(gen_ma + 1, 65535);
      if (gen_rpm > 0) begin
        mag = $urandom_range(0, gen_rpm - 1);
        it.motor_speed_rpm = $urandom_range(0, 1) ? -mag : mag;
      end
    end
    return it;
  endfunction

  task automatic send_item(input item_t it, input bit typed, input status_t want,
                           input bit rush);
    int gap;
    if (sent_cnt % 40 == 0) in_calm = ($urandom_range(0, 2) == 0);
    sent_cnt++;
    if (it.kind != KIND_NONE) counted++;
    gap = (rush || in_calm) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.motor_speed_rpm, it.motor_current_ma, it.sensor_seen, it.now_ms,
                  it.new_mode};
    in_tuser  <= it.kind;
    ref_typed <= typed;
    ref_want  <= want;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and wait until every owed status has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (status_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[CFG_DW-1:0];
    if (idx == CFG_STALL_CUR) gen_ma = value;
    if (idx == CFG_STALL_SPD) gen_rpm = value;
    @(posedge clk);
  endtask

  function automatic int pick_mv();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return MAX_MV;
      2:       return -MAX_MV;
      default: return int'($urandom_range(0, 32767)) - 16384;
    endcase
  endfunction

  task automatic write_settings(input int ph);
    if (ph == 0) begin
      // ends of the ranges; forward and reverse beyond the clamp, stalls impossible
      write_reg(CFG_FORWARD_MV, 16383);
      write_reg(CFG_REVERSE_MV, -16384);
      write_reg(CFG_INDEX_MV, 12000);
      write_reg(CFG_UNJAM_MV, 12000);
      write_reg(CFG_STALL_CUR, 65535);
      write_reg(CFG_STALL_SPD, 0);
      write_reg(CFG_STALL_DWELL, 65535);
      write_reg(CFG_RETRY_LIMIT, 15);
    end else if (ph == 1) begin
      // stall-prone settings: nearly every tick stalls, jam on first dwell
      write_reg(CFG_FORWARD_MV, -12000);
      write_reg(CFG_REVERSE_MV, 12000);
      write_reg(CFG_INDEX_MV, -12000);
      write_reg(CFG_UNJAM_MV, -12000);
      write_reg(CFG_STALL_CUR, 0);
      write_reg(CFG_STALL_SPD, 4095);
      write_reg(CFG_STALL_DWELL, 0);
      write_reg(CFG_RETRY_LIMIT, 0);
    end else begin
      write_reg(CFG_FORWARD_MV, pick_mv());
      write_reg(CFG_REVERSE_MV, pick_mv());
      write_reg(CFG_INDEX_MV, pick_mv());
      write_reg(CFG_UNJAM_MV, pick_mv());
      write_reg(CFG_STALL_CUR, $urandom_range(500, 3000));
      write_reg(CFG_STALL_SPD, $urandom_range(4, 200));
      write_reg(CFG_STALL_DWELL, $urandom_range(0, 300));
      write_reg(CFG_RETRY_LIMIT, ($urandom_range(0, 3) == 0) ? 15 : $urandom_range(0, 4));
    end
    cfg_we <= 1'b0;
  endtask

  // one run: usually a mode change, then ticks that slip in and out of stall
  task automatic run_episode();
    item_t it;
    int    len;
    int    r;
    bit    stalled;
    if ($urandom_range(0, 4) != 0) begin
      it = random_item();
      it.kind = KIND_MODE;
      send_item(it, 1'b0, '0, 1'b0);
    end
    stalled = $urandom_range(0, 1);
    len     = $urandom_range(5, 40);
    repeat (len) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_item(random_item(), 1'b0, '0, 1'b0);   // noise, any kind
      end else if (r == 1) begin
        it = random_item();
        it.kind = KIND_CLEAR;
        send_item(it, 1'b0, '0, 1'b0);
      end else begin
        if ($urandom_range(0, 5) == 0) stalled = !stalled;
        send_item(next_tick(stalled), 1'b0, '0, 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    int target;
    // directed list under reset settings
    add_row(make_item(KIND_NONE, MODE_INDEX, 32'hFFFF_FFFF, 1, 65535, -1), 1,
            pack_status(0, 0, 0, 0, 0, 0, MODE_STOP));
    add_row(make_item(KIND_TICK, MODE_STOP, 32'h0, 1, 0, 0), 1,
            pack_status(0, 0, 1, 0, 0, 0, MODE_STOP));
    add_row(make_item(KIND_MODE, MODE_FWD, 32'h0, 0, 0, 0), 1,
            pack_status(0, 0, 1, 0, 0, 0, MODE_FWD));
    // speed of -4096 counts as full speed, so no stall
    add_row(make_item(KIND_TICK, MODE_STOP, 32'hFFFF_FF00, 0, 65535, -4096), 1,
            pack_status(12000, 0, 0, 0, 0, 0, MODE_FWD));
    // stall starts just before the clock wraps, dwell ends after it
    add_row(make_item(KIND_TICK, MODE_STOP, 32'hFFFF_FF10, 0, 65535, 0), 0, '0);
    add_row(make_item(KIND_TICK, MODE_STOP, 32'h0000_000A, 0, 2001, -4), 0, '0);
    add_row(make_item(KIND_TICK, MODE_STOP, 32'd100, 0, 0, 0), 0, '0);
    add_row(make_item(KIND_TICK, MODE_STOP, 32'd210, 0, 0, 0), 0, '0);
    add_row(make_item(KIND_TICK, MODE_STOP, 32'd710, 0, 0, 4095), 0, '0);
    add_row(make_item(KIND_CLEAR, MODE_STOP, 32'd0, 0, 0, 0), 0, '0);
    add_row(make_item(KIND_MODE, MODE_REV, 32'd0, 0, 0, 0), 1,
            pack_status(12000, 0, 0, 0, 0, 0, MODE_REV));
    add_row(make_item(KIND_TICK, MODE_STOP, 32'd1000, 0, 100, 100), 1,
            pack_status(-12000, 0, 0, 0, 0, 0, MODE_REV));
    add_row(make_item(KIND_MODE, MODE_INDEX, 32'd0, 0, 0, 0), 0, '0);
    add_row(make_item(KIND_TICK, MODE_STOP, 32'd1010, 0, 0, 0), 0, '0);
    // object reaches the sensor: stop and latch index done
    add_row(make_item(KIND_TICK, MODE_STOP, 32'd1020, 1, 0, 0), 1,
            pack_status(0, 0, 1, 1, 0, 0, MODE_INDEX));
    add_row(make_item(KIND_TICK, MODE_STOP, 32'd1030, 0, 0, 0), 0, '0);
    add_row(make_item(KIND_MODE, MODE_INDEX, 32'd0, 0, 0, 0), 0, '0);
    add_row(make_item(KIND_MODE, MODE_STOP, 32'd0, 0, 0, 0), 0, '0);
    add_row(make_item(KIND_TICK, MODE_STOP, 32'd1040, 1, 65535, 1), 0, '0);
    add_row(make_item(KIND_NONE, MODE_STOP, 32'd0, 0, 0, 0), 0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want, 1'b0);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_settings(ph);
      clock_ms = (ph == 3) ? 32'hFFFF_FE00 : $urandom();
      if (ph == 2) begin
        // output side holds off while items keep coming back to back
        hold_req <= hold_req + 1;
        repeat (24) send_item(next_tick($urandom_range(0, 1)), 1'b0, '0, 1'b1);
      end
      target = counted + PHASE_ITEMS;
      while (counted < target) run_episode();
      drain();
    end

    if (err_cnt == 0 && status_q.size() == 0)
      $display("conveyor_jam_recovery_controller_core_tb OK");
    else
      $display("conveyor_jam_recovery_controller_core_tb NOT OK");
    $finish;
  end

endmodule
